// File: hdl/tsst_pkg.sv
package tsst_pkg;

  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BOUND_W = SLOT_W + 2;

  // x / 3 == (x * THIRD_RECIP) >> THIRD_SHIFT for every x below 2**SLOT_W
  localparam int unsigned THIRD_RECIP = 683;
  localparam int unsigned THIRD_SHIFT = 11;
  localparam int unsigned THIRD_W     = SLOT_W - 1;
  localparam int unsigned PROD_W      = 2 * SLOT_W;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } tsst_state_e;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_slot;
  } tsst_result_t;

endpackage

// File: hdl/tsst_in_if.sv
interface tsst_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic        [tsst_pkg::SLOT_W-1:0]  slot;
  logic signed [tsst_pkg::VALUE_W-1:0] value;
  logic        [tsst_pkg::SLOT_W-1:0]  lo_bound;
  logic        [tsst_pkg::SLOT_W-1:0]  hi_bound;

  modport source (output valid, kind, slot, value, lo_bound, hi_bound, input ready);
  modport sink   (input valid, kind, slot, value, lo_bound, hi_bound, output ready);
endinterface

// File: hdl/tsst_out_if.sv
interface tsst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [tsst_pkg::SLOT_W-1:0] match_slot;

  modport source (output valid, found, match_slot, input ready);
  modport sink   (input valid, found, match_slot, output ready);
endinterface

// File: hdl/tsst_store.sv
module tsst_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic signed [WIDTH-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr1_i,
  input  logic [AW-1:0]           rd_addr2_i,
  output logic signed [WIDTH-1:0] rd_data1_o,
  output logic signed [WIDTH-1:0] rd_data2_o
);

  logic signed [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data1_o <= mem_q[rd_addr1_i];
      rd_data2_o <= mem_q[rd_addr2_i];
    end
  end

endmodule

// File: hdl/tsst_search.sv
module tsst_search #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned WORD_WIDTH  = 32,
  parameter int unsigned AW          = $clog2(STORE_DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tsst_pkg::SLOT_W-1:0]        lo_i,
  input  logic [tsst_pkg::SLOT_W-1:0]        hi_i,
  input  logic signed [WORD_WIDTH-1:0]       key_i,
  output logic                               rd_en_o,
  output logic [AW-1:0]                      rd_addr1_o,
  output logic [AW-1:0]                      rd_addr2_o,
  input  logic signed [WORD_WIDTH-1:0]       rd_data1_i,
  input  logic signed [WORD_WIDTH-1:0]       rd_data2_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output tsst_pkg::tsst_result_t             res_o
);

  localparam int unsigned SW = tsst_pkg::SLOT_W;
  localparam int unsigned BW = tsst_pkg::BOUND_W;

  tsst_pkg::tsst_state_e state_q, state_d;

  logic signed [BW-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic        [SW-1:0]         mid1_q, mid1_d, mid2_q, mid2_d;
  logic                         oob1_q, oob1_d, oob2_q, oob2_d;
  logic signed [WORD_WIDTH-1:0] key_q, key_d;
  tsst_pkg::tsst_result_t       res_q, res_d;

  logic [SW-1:0]                 diff;
  logic [tsst_pkg::PROD_W-1:0]   prod;
  logic [tsst_pkg::THIRD_W-1:0]  third;
  logic [SW-1:0]                 m1, m2;
  logic signed [WORD_WIDTH-1:0]  w1, w2;
  logic signed [BW-1:0]          nlo, nhi;

  always_comb begin
    diff  = SW'(hi_q - lo_q);
    prod  = tsst_pkg::PROD_W'(diff) * tsst_pkg::PROD_W'(tsst_pkg::THIRD_RECIP);
    third = prod[tsst_pkg::THIRD_SHIFT +: tsst_pkg::THIRD_W];
    m1    = lo_q[SW-1:0] + SW'(third);
    m2    = hi_q[SW-1:0] - SW'(third);
    w1    = oob1_q ? '0 : rd_data1_i;
    w2    = oob2_q ? '0 : rd_data2_i;
  end

  always_comb begin
    state_d    = state_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid1_d     = mid1_q;
    mid2_d     = mid2_q;
    oob1_d     = oob1_q;
    oob2_d     = oob2_q;
    key_d      = key_q;
    res_d      = res_q;
    nlo        = lo_q;
    nhi        = hi_q;
    rd_en_o    = 1'b0;
    rd_addr1_o = AW'(m1);
    rd_addr2_o = AW'(m2);
    busy_o     = 1'b1;
    res_valid_o = 1'b0;
    unique case (state_q)
      tsst_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          lo_d  = BW'(lo_i);
          hi_d  = BW'(hi_i);
          key_d = key_i;
          res_d = '0;
          state_d = (hi_i >= lo_i) ? tsst_pkg::ST_PROBE : tsst_pkg::ST_DONE;
        end
      end
      tsst_pkg::ST_PROBE: begin
        rd_en_o = 1'b1;
        mid1_d  = m1;
        mid2_d  = m2;
        oob1_d  = 32'(m1) >= STORE_DEPTH;
        oob2_d  = 32'(m2) >= STORE_DEPTH;
        state_d = tsst_pkg::ST_CMP;
      end
      tsst_pkg::ST_CMP: begin
        priority if (w1 == key_q) begin
          res_d   = '{found: 1'b1, match_slot: mid1_q};
          state_d = tsst_pkg::ST_DONE;
        end else if (w2 == key_q) begin
          res_d   = '{found: 1'b1, match_slot: mid2_q};
          state_d = tsst_pkg::ST_DONE;
        end else begin
          priority if (key_q < w1) begin
            nhi = $signed(BW'(mid1_q)) - BW'(1);
          end else if (key_q > w2) begin
            nlo = $signed(BW'(mid2_q)) + BW'(1);
          end else begin
            nlo = $signed(BW'(mid1_q)) + BW'(1);
            nhi = $signed(BW'(mid2_q)) - BW'(1);
          end
          lo_d    = nlo;
          hi_d    = nhi;
          state_d = (nhi < nlo) ? tsst_pkg::ST_DONE : tsst_pkg::ST_PROBE;
        end
      end
      tsst_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tsst_pkg::ST_IDLE;
        end
      end
      default: state_d = tsst_pkg::ST_IDLE;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid1_q <= mid1_d;
    mid2_q <= mid2_d;
    oob1_q <= oob1_d;
    oob2_q <= oob2_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

  // probes stay inside the live range
  a_mids_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsst_pkg::ST_CMP |->
      ($signed(BW'(mid1_q)) >= lo_q) && (mid1_q <= mid2_q) && ($signed(BW'(mid2_q)) <= hi_q))
    else $error("probe points outside search range");

  // every round strictly narrows the range
  a_range_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsst_pkg::ST_CMP && state_d == tsst_pkg::ST_PROBE) |->
      ((hi_d - lo_d) < (hi_q - lo_q)))
    else $error("search range did not narrow");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_q.found) |-> (res_q.match_slot == '0))
    else $error("miss result carries nonzero slot");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tsst_pkg::ST_IDLE) |=> (state_q != tsst_pkg::ST_IDLE) || $past(res_ready_i))
    else $error("search left busy state without result transfer");

endmodule

// File: hdl/ternary_search_sorted_table.sv
// Sorted word store with ternary search. A load transfer writes one signed word
// into the store and gives no result; loads to a slot at or beyond STORE_DEPTH
// are dropped. A search transfer gives one result (found, match_slot). Each
// search round forms both third points and reads them through the store's two
// read ports, then compares the registered words and narrows the range. A range
// of n slots needs at most ceil(log3(n+1)) rounds: 7 for a full 1024-slot range,
// none for an empty range. Loads can transfer every cycle while no search is in
// progress. Input is taken whenever no search is in progress, also while a
// result waits in the output register. Slots must be loaded before a search
// probes them.
module ternary_search_sorted_table #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsst_in_if.sink   in_i,
  tsst_out_if.source out_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic                         in_xfer;
  logic                         load_en;
  logic                         start;
  logic signed [WORD_WIDTH-1:0] key;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr1, rd_addr2;
  logic signed [WORD_WIDTH-1:0] rd_data1, rd_data2;
  logic                         busy;
  logic                         res_valid;
  logic                         res_ready;
  tsst_pkg::tsst_result_t       res;

  logic                         out_valid_q;
  tsst_pkg::tsst_result_t       out_q;

  assign in_i.ready = !busy;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign key        = WORD_WIDTH'(in_i.value);
  assign load_en    = in_xfer && (in_i.kind == tsst_pkg::KIND_LOAD) &&
                      (32'(in_i.slot) < STORE_DEPTH);
  assign start      = in_xfer && (in_i.kind == tsst_pkg::KIND_SEARCH);

  tsst_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (WORD_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (load_en),
    .wr_addr_i  (AW'(in_i.slot)),
    .wr_data_i  (key),
    .rd_en_i    (rd_en),
    .rd_addr1_i (rd_addr1),
    .rd_addr2_i (rd_addr2),
    .rd_data1_o (rd_data1),
    .rd_data2_o (rd_data2)
  );

  tsst_search #(
    .STORE_DEPTH (STORE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH),
    .AW          (AW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .lo_i        (in_i.lo_bound),
    .hi_i        (in_i.hi_bound),
    .key_i       (key),
    .rd_en_o     (rd_en),
    .rd_addr1_o  (rd_addr1),
    .rd_addr2_o  (rd_addr2),
    .rd_data1_i  (rd_data1),
    .rd_data2_i  (rd_data2),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = out_q.found;
  assign out_o.match_slot = out_q.match_slot;

endmodule

// File: verif/tsst_result_monitor.sv
module tsst_result_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsst_in_if          in_mon,
  tsst_out_if         out_mon,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  localparam int unsigned SW = tsst_pkg::SLOT_W;
  localparam int unsigned VW = tsst_pkg::VALUE_W;

  logic signed [VW-1:0]      word_mirror [1024];
  tsst_pkg::tsst_result_t    search_outcomes_q [$];
  int unsigned               mismatch_count;

  assign errors_o = mismatch_count;

  initial begin
    mismatch_count = 0;
    foreach (word_mirror[i]) word_mirror[i] = '0;
  end

  function automatic tsst_pkg::tsst_result_t ternary_lookup(
      input logic signed [VW-1:0] key, input int lo, input int hi);
    tsst_pkg::tsst_result_t res;
    int third, m1, m2;
    res = '0;
    while (hi >= lo) begin
      third = (hi - lo) / 3;
      m1 = lo + third;
      m2 = hi - third;
      if (word_mirror[m1] == key) begin
        res.found = 1'b1;
        res.match_slot = SW'(m1);
        return res;
      end
      if (word_mirror[m2] == key) begin
        res.found = 1'b1;
        res.match_slot = SW'(m2);
        return res;
      end
      if (key < word_mirror[m1]) begin
        hi = m1 - 1;
      end else if (key > word_mirror[m2]) begin
        lo = m2 + 1;
      end else begin
        lo = m1 + 1;
        hi = m2 - 1;
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    tsst_pkg::tsst_result_t want;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        if (search_outcomes_q.size() == 0) begin
          flag_error($sformatf("result transfer with none pending: found %0b slot %0d",
                               out_mon.found, out_mon.match_slot));
        end else begin
          want = search_outcomes_q.pop_front();
          if (out_mon.found !== want.found)
            flag_error($sformatf("found: expected %0b, got %0b", want.found, out_mon.found));
          if (out_mon.match_slot !== want.match_slot)
            flag_error($sformatf("match_slot: expected %0d, got %0d",
                                 want.match_slot, out_mon.match_slot));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == tsst_pkg::KIND_LOAD) begin
          word_mirror[in_mon.slot] = in_mon.value;
        end else begin
          search_outcomes_q.push_back(ternary_lookup(in_mon.value, int'(in_mon.lo_bound),
                                                     int'(in_mon.hi_bound)));
        end
      end
      pending_o <= search_outcomes_q.size();
    end else begin
      pending_o <= 0;
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;

  localparam int unsigned SW = tsst_pkg::SLOT_W;
  localparam int unsigned VW = tsst_pkg::VALUE_W;

  localparam logic signed [VW-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic clk_i;
  logic rst_ni;

  tsst_in_if  in_ch ();
  tsst_out_if out_ch ();

  int unsigned pending;
  int unsigned error_total;
  int unsigned cycle_count = 0;
  int unsigned item_count = 0;
  int          in_calm = 0;
  int          out_calm = 0;

  logic signed [VW-1:0] shadow [1024];
  logic                 loaded [1024];

  ternary_search_sorted_table uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tsst_result_monitor monitor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .pending_o(pending),
    .errors_o (error_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 17);
  endfunction

  initial begin : result_sink
    int stall;
    forever begin
      stall = draw_wait(out_calm);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  task automatic send_item(input logic kind, input logic [SW-1:0] slot,
                           input logic signed [VW-1:0] value,
                           input logic [SW-1:0] lo, input logic [SW-1:0] hi);
    int gap;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.slot     <= slot;
    in_ch.value    <= value;
    in_ch.lo_bound <= lo;
    in_ch.hi_bound <= hi;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    item_count++;
    if (kind == tsst_pkg::KIND_LOAD) begin
      shadow[slot] = value;
      loaded[slot] = 1'b1;
    end
  endtask

  // unused fields carry random bits
  task automatic load_word(input int slot, input logic signed [VW-1:0] value);
    send_item(tsst_pkg::KIND_LOAD, SW'(slot), value, SW'($urandom), SW'($urandom));
  endtask

  task automatic search_key(input logic signed [VW-1:0] key, input int lo, input int hi);
    send_item(tsst_pkg::KIND_SEARCH, SW'($urandom), key, SW'(lo), SW'(hi));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic signed [VW-1:0] pick_key(input int lo, input int hi);
    int idx;
    idx = $urandom_range(lo, hi);
    case ($urandom_range(0, 5))
      0, 1, 2: return shadow[idx];
      3:       return shadow[idx] + ($urandom_range(0, 1) ? 1 : -1);
      4:       return $urandom;
      default: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
    endcase
  endfunction

  // mode 0..2: ascending with growing step size, 3: scrambled
  task automatic load_run(input int base, input int len, input int mode);
    longint cur;
    longint step_max;
    int k;
    case (mode)
      0:       step_max = 3;
      1:       step_max = 1000;
      default: step_max = 1 << 22;
    endcase
    if (mode >= 2) cur = longint'(WORD_MIN) + $urandom_range(0, 1000);
    else cur = longint'($signed($urandom));
    for (k = 0; k < len; k++) begin
      if (mode == 3) load_word(base + k, $urandom);
      else load_word(base + k, cur[31:0]);
      cur += $urandom_range(0, step_max);
      if (cur > WORD_MAX) cur = WORD_MAX;
    end
  endtask

  task automatic probe_run(input int lo_lim, input int hi_lim, input int count);
    int a, b, k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        a = lo_lim;
        b = hi_lim;
      end else begin
        a = $urandom_range(lo_lim, hi_lim);
        b = $urandom_range(a, hi_lim);
      end
      search_key(pick_key(a, b), a, b);
    end
  endtask

  task automatic empty_search();
    int a;
    a = $urandom_range(1, 1023);
    search_key($urandom, a, $urandom_range(0, a - 1));
  endtask

  // search inside whatever loaded run covers a random slot, or an empty range if none does
  task automatic stray_search();
    int s, a, b;
    s = $urandom_range(0, 1023);
    if (!loaded[s]) begin
      empty_search();
    end else begin
      a = s;
      b = s;
      while (a > 0 && loaded[a - 1]) a--;
      while (b < 1023 && loaded[b + 1]) b++;
      probe_run(a, b, $urandom_range(1, 3));
    end
  endtask

  initial begin : stimulus
    int base, len, stop_at;
    bit filled;
    foreach (loaded[i]) loaded[i] = 1'b0;
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= tsst_pkg::KIND_LOAD;
    in_ch.slot     <= '0;
    in_ch.value    <= '0;
    in_ch.lo_bound <= '0;
    in_ch.hi_bound <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_word(0, WORD_MIN);
    load_word(1, -1000);
    load_word(2, -1);
    load_word(3, 0);
    load_word(4, 1);
    load_word(5, 77);
    load_word(6, 5000);
    load_word(7, WORD_MAX);
    search_key(WORD_MIN, 0, 7);
    search_key(WORD_MAX, 0, 7);
    search_key(0, 0, 7);
    search_key(2, 0, 7);
    search_key(-5, 0, 7);
    search_key(5000, 2, 6);
    search_key(1, 4, 4);
    search_key(2, 4, 4);
    search_key(0, 6, 2);
    search_key(WORD_MAX, 1023, 0);
    // order broken at slot 5
    load_word(5, -2000);
    search_key(-2000, 0, 7);
    search_key(77, 0, 7);
    load_word(1023, 42);
    search_key(42, 1023, 1023);
    load_word(1022, 41);
    search_key(41, 1022, 1023);
    drain();

    filled = 1'b0;
    stop_at = 900;
    while (item_count < stop_at) begin
      if (!filled && item_count > 250) begin
        filled = 1'b1;
        load_run(0, 512, 2);
        search_key(shadow[0], 0, 511);
        search_key(shadow[511], 0, 511);
        search_key(WORD_MIN, 0, 511);
        search_key(WORD_MAX, 0, 511);
        probe_run(0, 511, 8);
      end
      base = $urandom_range(0, 1023);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(33, 200);
      else len = $urandom_range(1, 32);
      if (len > 1024 - base) len = 1024 - base;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          load_run(base, len, $urandom_range(0, 2));
          probe_run(base, base + len - 1, $urandom_range(1, 6));
        end
        6: begin
          load_run(base, len, 3);
          probe_run(base, base + len - 1, $urandom_range(1, 4));
        end
        7: stray_search();
        8: empty_search();
        default: load_word(base, $urandom);
      endcase
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (error_total == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
